FILE: sv/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int unsigned FieldW = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_REV    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_STALE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [FieldW-1:0] handle_index;
        logic [FieldW-1:0] handle_gen;
        logic [FieldW-1:0] data_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [9:0]        out_slot;
        logic [FieldW-1:0] out_gen;
        logic [9:0]        dense_index;
        logic              moved;
        logic [9:0]        moved_from;
        logic [10:0]       live_count;
    } t_rsp;

endpackage

FILE: sv/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map with generational handles, dense index space and reverse map.
// ----------------------------------------------------------------------------
// Allocate scans the free map one word at a time (32 slots per word, up to WORDS
// words); an allocate is refused when the live count has reached the configured
// maximum or the table is full.
// Throughput: one command at a time; busy drops in the strobe cycle, so the next
// command can be taken at the edge that ends it. The receiver cannot stall.
// After reset a clearing pass runs (busy high) over the generation, binding and free-map tables.
// ----------------------------------------------------------------------------
module generational_handle_table
    import ght_pkg::*;
#(
    parameter int unsigned SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_strobe,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned WORDS = (SLOTS + 31) / 32;
    localparam int unsigned WW = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_CHK, S_SCAN, S_AGEN, S_FRD, S_FMV, S_OUT
    } t_state;

    typedef struct packed {
        logic          bound;
        logic [SW-1:0] dense;
    } t_bind;

    typedef struct packed {
        logic          bound;
        logic [SW-1:0] dense;
        logic [31:0]   gen;
    } t_slot;

    logic [31:0]   r_gen_mem   [SLOTS];
    t_bind         r_bind_mem  [SLOTS];
    logic [SW-1:0] r_owner_mem [SLOTS];
    logic [31:0]   r_free_mem  [WORDS];

    t_state        r_state;
    t_req          r_req;
    t_slot         r_sd;
    logic [SW-1:0] r_od;
    logic [31:0]   r_fw;
    logic [WW-1:0] r_wi;
    logic [SW-1:0] r_clr;
    logic [CW-1:0] r_live;
    logic [10:0]   r_max;
    logic [SW-1:0] r_s;
    t_rsp          r_rsp;
    logic          r_strobe;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;

    logic [11:0] live_ext;
    logic        hidx_ok;
    logic        gen_ok;
    logic [4:0]  ffs;
    logic        ffs_hit;
    logic [SW-1:0] last;
    logic [SW:0] sel_full;

    assign live_ext = 12'(r_live);
    assign hidx_ok  = (r_req.handle_index < 32'(SLOTS));
    assign gen_ok   = r_sd.bound && (r_sd.gen == r_req.handle_gen)
                      && (12'(r_sd.dense) < live_ext);
    assign last     = SW'(r_live - CW'(1));
    assign sel_full = (SW+1)'({r_wi, 5'd0}) + (SW+1)'(ffs);

    always_comb begin
        ffs     = '0;
        ffs_hit = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (r_fw[i] && ((32'(r_wi) * 32) + 32'(i) < SLOTS)) begin
                ffs     = 5'(i);
                ffs_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_live   <= '0;
            r_max    <= 11'd1024;
            r_strobe <= 1'b0;
            r_wi     <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            unique case (r_state)
                S_CLR: begin
                    r_gen_mem[r_clr]  <= '0;
                    r_bind_mem[r_clr] <= '0;
                    if (32'(r_clr) < WORDS) begin
                        r_free_mem[r_clr[WW-1:0]] <= '1;
                    end
                    r_clr <= r_clr + SW'(1);
                    if (32'(r_clr) == SLOTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_rsp   <= '0;
                        r_wi    <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_sd  <= {r_bind_mem[r_req.handle_index[SW-1:0]],
                              r_gen_mem[r_req.handle_index[SW-1:0]]};
                    r_od  <= r_owner_mem[r_req.data_index[SW-1:0]];
                    r_fw  <= r_free_mem[r_wi];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_OUT;
                    unique case (t_cmd'(r_req.cmd))
                        CMD_ALLOC: begin
                            if (12'(r_max) <= live_ext || 32'(r_live) >= SLOTS) begin
                                r_rsp.status <= ST_FULL;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        CMD_FREE, CMD_LOOKUP: begin
                            if (!hidx_ok) begin
                                r_rsp.status <= ST_RANGE;
                            end else if (!gen_ok) begin
                                r_rsp.status <= ST_STALE;
                            end else if (r_req.cmd == CMD_LOOKUP) begin
                                r_rsp.dense_index <= 10'(r_sd.dense);
                            end else begin
                                r_gen_mem[r_req.handle_index[SW-1:0]] <= r_sd.gen + 32'd1;
                                r_bind_mem[r_req.handle_index[SW-1:0]] <= '0;
                                r_s <= r_req.handle_index[SW-1:0];
                                r_rsp.dense_index <= 10'(r_sd.dense);
                                r_state <= S_FRD;
                            end
                        end
                        CMD_REV: begin
                            if (r_req.data_index >= 32'(r_live)) begin
                                r_rsp.status <= ST_RANGE;
                            end else begin
                                r_sd.gen <= r_gen_mem[r_od];
                                r_rsp.out_slot <= 10'(r_od);
                                r_state <= S_FRD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    if (ffs_hit) begin
                        r_free_mem[r_wi] <= r_fw & ~(32'd1 << ffs);
                        r_bind_mem[SW'(sel_full)] <= '{bound: 1'b1, dense: SW'(r_live)};
                        r_owner_mem[SW'(r_live)] <= SW'(sel_full);
                        r_s               <= SW'(sel_full);
                        r_rsp.out_slot    <= 10'(sel_full);
                        r_rsp.dense_index <= 10'(r_live);
                        r_live  <= r_live + CW'(1);
                        r_state <= S_AGEN;
                    end else if (32'(r_wi) == WORDS - 1) begin
                        r_rsp.status <= ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_wi    <= r_wi + WW'(1);
                        r_state <= S_RD;
                    end
                end
                S_AGEN: begin
                    r_rsp.out_gen <= r_gen_mem[r_s];
                    r_state <= S_OUT;
                end
                S_FRD: begin
                    if (r_req.cmd == CMD_REV) begin
                        r_rsp.out_gen <= r_sd.gen;
                        r_state <= S_OUT;
                    end else begin
                        r_fw  <= r_free_mem[WW'(r_s >> 5)];
                        r_od  <= r_owner_mem[last];
                        r_state <= S_FMV;
                    end
                end
                S_FMV: begin
                    r_free_mem[WW'(r_s >> 5)] <= r_fw | (32'd1 << 5'(r_s));
                    if (r_sd.dense != last) begin
                        r_owner_mem[r_sd.dense] <= r_od;
                        r_bind_mem[r_od] <= '{bound: 1'b1, dense: r_sd.dense};
                        r_rsp.moved      <= 1'b1;
                        r_rsp.moved_from <= 10'(last);
                    end
                    r_live  <= r_live - CW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_rsp.live_count <= 11'(r_live);
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
